/* rtl/core/tcc_pkg.sv */
package tcc_pkg;

	localparam int WORD_BITS     = 16;
	localparam int LOW_PART_BITS = 5;
	localparam int LOW_PART_LSB  = 11;
	localparam int ORIGIN_BITS   = 12;
	localparam int SPAN_BITS     = 13;
	localparam int DISP_BITS     = 16;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_X_TOUCH_SPAN     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_DISPLAY_SPAN   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_TOUCH_ORIGIN   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_DISPLAY_ORIGIN = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_TOUCH_SPAN     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_DISPLAY_SPAN   = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_TOUCH_ORIGIN   = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_DISPLAY_ORIGIN = 3'd7;

	localparam logic signed [DISP_BITS-1:0] POS_MAX = 16'sh7fff;
	localparam logic signed [DISP_BITS-1:0] POS_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [SPAN_BITS-1:0] touch_span;
		logic signed [DISP_BITS-1:0] display_span;
		logic [ORIGIN_BITS-1:0]      touch_origin;
		logic signed [DISP_BITS-1:0] display_origin;
	} axis_cfg_t;

	typedef struct packed {
		logic signed [DISP_BITS-1:0] pos;
		logic                        zero_span;
	} lane_res_t;

endpackage

/* rtl/core/tcc_lane.sv */
module tcc_lane import tcc_pkg::*; #(
	parameter int RAW_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [WORD_BITS-1:0] hi_word,
	input  logic [WORD_BITS-1:0] lo_word,
	input  axis_cfg_t            cfg,
	output logic                 out_valid,
	output lane_res_t            res
);

	localparam int HIGH_BITS = RAW_BITS - LOW_PART_BITS;
	localparam int DW = ((RAW_BITS > ORIGIN_BITS) ? RAW_BITS : ORIGIN_BITS) + 1;
	localparam int PW = DW + DISP_BITS;
	localparam int SW = PW + 2;

	logic [RAW_BITS-1:0]        raw;
	logic signed [DW-1:0]       diff_s1;
	logic signed [PW-1:0]       prod;
	logic signed [PW-1:0]       prod_s2;
	logic [PW-1:0]              mag_s3;
	logic                       neg_s3;
	logic [SPAN_BITS-1:0]       dmag;
	logic                       valid_s1, valid_s2, valid_s3;

	logic [SPAN_BITS-1:0]       dv_rem_s4 [0:PW-1];
	logic [PW-1:0]              dv_num_s4 [0:PW-1];
	logic                       dv_neg_s4 [0:PW-1];
	logic                       dv_vld_s4 [0:PW-1];

	logic signed [PW:0]         quo;
	logic signed [SW-1:0]       sum;
	logic signed [SW-1:0]       sat_hi, sat_lo;
	lane_res_t                  res_s5;
	logic                       valid_s5;

	assign raw  = {hi_word[HIGH_BITS-1:0], lo_word[WORD_BITS-1:LOW_PART_LSB]};
	assign prod = diff_s1 * cfg.display_span;
	assign dmag = cfg.touch_span[SPAN_BITS-1] ? SPAN_BITS'(-cfg.touch_span)
	                                          : SPAN_BITS'(cfg.touch_span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= signed'(DW'(raw) - DW'(cfg.touch_origin));
		prod_s2 <= prod;
		mag_s3  <= prod_s2[PW-1] ? PW'(-prod_s2) : PW'(prod_s2);
		neg_s3  <= prod_s2[PW-1] ^ cfg.touch_span[SPAN_BITS-1];
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < PW; k++) begin : g_div
		logic [SPAN_BITS-1:0] rem_in;
		logic [PW-1:0]        num_in;
		logic                 neg_in, vld_in;
		logic [SPAN_BITS:0]   trial;
		logic                 take;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = mag_s3;
			assign neg_in = neg_s3;
			assign vld_in = valid_s3;
		end else begin : g_next
			assign rem_in = dv_rem_s4[k-1];
			assign num_in = dv_num_s4[k-1];
			assign neg_in = dv_neg_s4[k-1];
			assign vld_in = dv_vld_s4[k-1];
		end

		assign trial = {rem_in, num_in[PW-1]};
		assign take  = trial >= {1'b0, dmag};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s4[k] <= 1'b0;
			end else begin
				dv_vld_s4[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s4[k] <= take ? SPAN_BITS'(trial - {1'b0, dmag}) : trial[SPAN_BITS-1:0];
			dv_num_s4[k] <= {num_in[PW-2:0], take};
			dv_neg_s4[k] <= neg_in;
		end
	end

	assign quo    = dv_neg_s4[PW-1] ? -signed'({1'b0, dv_num_s4[PW-1]})
	                                : signed'({1'b0, dv_num_s4[PW-1]});
	assign sum    = SW'(quo) + SW'(cfg.display_origin);
	assign sat_hi = SW'(POS_MAX);
	assign sat_lo = SW'(POS_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= dv_vld_s4[PW-1];
		end
	end

	always_ff @(posedge clk) begin
		res_s5.zero_span <= cfg.touch_span == '0;
		if (cfg.touch_span == '0) begin
			res_s5.pos <= cfg.display_origin;
		end else if (sum > sat_hi) begin
			res_s5.pos <= POS_MAX;
		end else if (sum < sat_lo) begin
			res_s5.pos <= POS_MIN;
		end else begin
			res_s5.pos <= sum[DISP_BITS-1:0];
		end
	end

	assign out_valid = valid_s5;
	assign res       = res_s5;

endmodule

/* rtl/core/tcc_merge.sv */
module tcc_merge import tcc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        lane_valid,
	input  lane_res_t                   x_res,
	input  lane_res_t                   y_res,
	output logic                        done,
	output logic signed [DISP_BITS-1:0] x_pos,
	output logic signed [DISP_BITS-1:0] y_pos,
	output logic                        span_fault
);

	logic                        done_q;
	logic signed [DISP_BITS-1:0] x_pos_q, y_pos_q;
	logic                        fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_pos_q <= x_res.pos;
		y_pos_q <= y_res.pos;
		fault_q <= x_res.zero_span | y_res.zero_span;
	end

	assign done       = done_q;
	assign x_pos      = x_pos_q;
	assign y_pos      = y_pos_q;
	assign span_fault = fault_q;

endmodule

/* rtl/core/touch_coordinate_calibrate_core.sv */
// channel   direction  handshake                 payload
// command   in         start, busy               first_word, second_word, third_word
// result    out        done (one-cycle strobe)   x_pos, y_pos, span_fault
// config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// one word is taken every cycle; busy stays low
// latency is RAW_BITS-dependent, set by the bit-per-stage divider in each axis lane
// arst_n clears all valid flags and loads spans of 1 and origins of 0
// done cannot be held off; the result is on the ports for that one cycle only
module touch_coordinate_calibrate_core import tcc_pkg::*; #(
	parameter int RAW_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [WORD_BITS-1:0]        first_word,
	input  logic [WORD_BITS-1:0]        second_word,
	input  logic [WORD_BITS-1:0]        third_word,
	output logic                        done,
	output logic signed [DISP_BITS-1:0] x_pos,
	output logic signed [DISP_BITS-1:0] y_pos,
	output logic                        span_fault,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [DISP_BITS-1:0]        cfg_data
);

	localparam int DW  = ((RAW_BITS > ORIGIN_BITS) ? RAW_BITS : ORIGIN_BITS) + 1;
	localparam int LAT = DW + DISP_BITS + 5;

	axis_cfg_t x_cfg_q, y_cfg_q;
	logic      accept;
	logic      x_valid, y_valid;
	lane_res_t x_res, y_res;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_cfg_q.touch_span     <= SPAN_BITS'(1);
			x_cfg_q.display_span   <= DISP_BITS'(1);
			x_cfg_q.touch_origin   <= '0;
			x_cfg_q.display_origin <= '0;
			y_cfg_q.touch_span     <= SPAN_BITS'(1);
			y_cfg_q.display_span   <= DISP_BITS'(1);
			y_cfg_q.touch_origin   <= '0;
			y_cfg_q.display_origin <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_TOUCH_SPAN:     x_cfg_q.touch_span     <= cfg_data[SPAN_BITS-1:0];
				REG_X_DISPLAY_SPAN:   x_cfg_q.display_span   <= cfg_data;
				REG_X_TOUCH_ORIGIN:   x_cfg_q.touch_origin   <= cfg_data[ORIGIN_BITS-1:0];
				REG_X_DISPLAY_ORIGIN: x_cfg_q.display_origin <= cfg_data;
				REG_Y_TOUCH_SPAN:     y_cfg_q.touch_span     <= cfg_data[SPAN_BITS-1:0];
				REG_Y_DISPLAY_SPAN:   y_cfg_q.display_span   <= cfg_data;
				REG_Y_TOUCH_ORIGIN:   y_cfg_q.touch_origin   <= cfg_data[ORIGIN_BITS-1:0];
				REG_Y_DISPLAY_ORIGIN: y_cfg_q.display_origin <= cfg_data;
				default: ;
			endcase
		end
	end

	// x reading: high part in second word, low part in third
	tcc_lane #(.RAW_BITS(RAW_BITS)) u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.hi_word   (second_word),
		.lo_word   (third_word),
		.cfg       (x_cfg_q),
		.out_valid (x_valid),
		.res       (x_res)
	);

	// y reading: high part in first word, low part in second
	tcc_lane #(.RAW_BITS(RAW_BITS)) u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.hi_word   (first_word),
		.lo_word   (second_word),
		.cfg       (y_cfg_q),
		.out_valid (y_valid),
		.res       (y_res)
	);

	tcc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (x_valid),
		.x_res      (x_res),
		.y_res      (y_res),
		.done       (done),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.span_fault (span_fault)
	);

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		x_valid == y_valid)
		else $error("axis lanes out of step");

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result missing after accepted word");

	a_fault_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (span_fault == ((x_cfg_q.touch_span == '0) || (y_cfg_q.touch_span == '0))))
		else $error("span fault does not match span registers");

endmodule
